// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define HAB_ASSERT_CLK(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("assertion failed");

// clocked assertion on the block clock and reset
`define HAB_ASSERT(lbl, prop) `HAB_ASSERT_CLK(lbl, clk, arst_n, prop)

`endif

// ===== rtl/hab_pkg.sv =====
// ----------------------------------------------------------------------------
// hab_pkg
// shared types and constants of the hot address bucket counter
// ----------------------------------------------------------------------------
package hab_pkg;

	localparam int DEF_ENTRIES = 512;
	localparam int DEF_TOP_N   = 10;

	localparam int TAG_W  = 28;
	localparam int HITS_W = 32;
	localparam int ADDR_W = 32;
	localparam int ENT_W  = TAG_W + HITS_W;

	localparam logic [ADDR_W-1:0] ACCESS_BASE = 32'h1000_0000;
	localparam logic [HITS_W-1:0] HITS_MAX    = '1;

	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	// scan control from the sequencer
	typedef struct packed {
		logic vld;
		logic first;
		logic report;
	} scan_ctl_t;

	// scan status back to the sequencer
	typedef struct packed {
		logic              match;
		logic [TAG_W-1:0]  sel_tag;
		logic [HITS_W-1:0] sel_hits;
	} scan_sts_t;

endpackage

// ===== rtl/hab_mem.sv =====
// ----------------------------------------------------------------------------
// hab_mem
// single-port-write, single-port-read table memory, registered read data
// ----------------------------------------------------------------------------
module hab_mem #(
	parameter int DEPTH = hab_pkg::DEF_ENTRIES,
	parameter int WIDTH = hab_pkg::ENT_W
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ===== rtl/hab_scan.sv =====
// ----------------------------------------------------------------------------
// hab_scan
// per-entry compare unit: tag match, and running min or max of the counts
// ----------------------------------------------------------------------------
module hab_scan #(
	parameter int ENTRIES = hab_pkg::DEF_ENTRIES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hab_pkg::scan_ctl_t         ctl,
	input  logic [$clog2(ENTRIES)-1:0] idx,
	input  logic [hab_pkg::TAG_W-1:0]  key,
	input  logic [hab_pkg::TAG_W-1:0]  rd_tag,
	input  logic [hab_pkg::HITS_W-1:0] rd_hits,
	output hab_pkg::scan_sts_t         sts,
	output logic [$clog2(ENTRIES)-1:0] sel_idx
);
	import hab_pkg::*;

	localparam int AW = $clog2(ENTRIES);

	logic [TAG_W-1:0]  sel_tag_q;
	logic [HITS_W-1:0] sel_hits_q;
	logic [AW-1:0]     sel_idx_q;
	logic              better;

	// report keeps the largest, access the smallest, lowest index wins ties
	always_comb begin
		priority if (ctl.first) begin
			better = 1'b1;
		end else if (ctl.report) begin
			better = rd_hits > sel_hits_q;
		end else begin
			better = rd_hits < sel_hits_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_idx_q <= '0;
		end else if (ctl.vld && better) begin
			sel_idx_q <= idx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vld && better) begin
			sel_tag_q  <= rd_tag;
			sel_hits_q <= rd_hits;
		end
	end

	assign sts.match    = ctl.vld && !ctl.report && (rd_tag == key);
	assign sts.sel_tag  = sel_tag_q;
	assign sts.sel_hits = sel_hits_q;
	assign sel_idx      = sel_idx_q;
endmodule

// ===== rtl/hot_address_bucket_counter.sv =====
// ----------------------------------------------------------------------------
// hot_address_bucket_counter
// access-frequency table of 16-byte buckets with top-n hottest report
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// request   in         start & !busy          op, access_offset
// result    out        strobe, one cycle      bucket_base, hit_count, found, last
//
// an access does one table read per cycle through the single read port, then
// one write-back
// a report makes one full scan of the table per result
// after reset a clearing pass over every entry holds busy high
// results cannot be stalled; busy stays high until the last one is out
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hot_address_bucket_counter #(
	parameter int ENTRIES = hab_pkg::DEF_ENTRIES,
	parameter int TOP_N   = hab_pkg::DEF_TOP_N
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       op,
	input  logic [hab_pkg::ADDR_W-1:0] access_offset,
	output logic                       strobe,
	output logic [hab_pkg::ADDR_W-1:0] bucket_base,
	output logic [hab_pkg::HITS_W-1:0] hit_count,
	output logic                       found,
	output logic                       last
);
	import hab_pkg::*;

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int RW = (TOP_N > 1) ? $clog2(TOP_N) : 1;

	localparam logic [1:0] S_CLR  = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]        state_q;
	logic [CW-1:0]     iss_q;
	logic [RW-1:0]     round_q;
	logic              op_q;
	logic [TAG_W-1:0]  key_q;
	logic              vld_s1;
	logic [AW-1:0]     idx_s1;

	logic              issuing;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [ENT_W-1:0]  wr_data;
	logic [ENT_W-1:0]  rd_data;
	logic [TAG_W-1:0]  rd_tag;
	logic [HITS_W-1:0] rd_hits;
	logic [HITS_W-1:0] inc_hits;
	logic [ADDR_W-1:0] phys;
	logic              scan_last;
	logic              round_last;
	logic              best_zero;
	scan_ctl_t         ctl;
	scan_sts_t         sts;
	logic [AW-1:0]     sel_idx;

	logic              strobe_q;
	logic [ADDR_W-1:0] base_q;
	logic [HITS_W-1:0] count_q;
	logic              found_q;
	logic              last_q;

	assign issuing    = (state_q == S_SCAN) && (iss_q < CW'(ENTRIES));
	assign rd_tag     = rd_data[ENT_W-1:HITS_W];
	assign rd_hits    = rd_data[HITS_W-1:0];
	assign inc_hits   = (rd_hits == HITS_MAX) ? rd_hits : rd_hits + HITS_W'(1);
	assign phys       = ACCESS_BASE + access_offset;
	assign scan_last  = idx_s1 == AW'(ENTRIES - 1);
	assign round_last = round_q == RW'(TOP_N - 1);
	assign best_zero  = sts.sel_hits == '0;

	assign ctl.vld    = vld_s1 && (state_q == S_SCAN);
	assign ctl.first  = idx_s1 == '0;
	assign ctl.report = op_q == OP_REPORT;

	hab_mem #(
		.DEPTH (ENTRIES),
		.WIDTH (ENT_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issuing),
		.rd_addr (iss_q[AW-1:0]),
		.rd_data (rd_data)
	);

	hab_scan #(
		.ENTRIES (ENTRIES)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.idx     (idx_s1),
		.key     (key_q),
		.rd_tag  (rd_tag),
		.rd_hits (rd_hits),
		.sts     (sts),
		.sel_idx (sel_idx)
	);

	// write port: clearing pass, in-place hit, victim fill or report zeroing
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = sel_idx;
		wr_data = '0;
		unique case (state_q)
			S_CLR: begin
				wr_en   = 1'b1;
				wr_addr = iss_q[AW-1:0];
			end
			S_SCAN: begin
				wr_en   = sts.match;
				wr_addr = idx_s1;
				wr_data = {key_q, inc_hits};
			end
			S_FIN: begin
				if (op_q == OP_ACCESS) begin
					wr_en   = 1'b1;
					wr_data = {key_q, HITS_W'(1)};
				end else begin
					wr_en   = !best_zero;
					wr_data = {sts.sel_tag, HITS_W'(0)};
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			iss_q    <= '0;
			round_q  <= '0;
			op_q     <= OP_ACCESS;
			vld_s1   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			vld_s1   <= issuing;
			strobe_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					if (iss_q == CW'(ENTRIES - 1)) begin
						iss_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						iss_q <= iss_q + CW'(1);
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q    <= op;
						iss_q   <= '0;
						round_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issuing) begin
						iss_q <= iss_q + CW'(1);
					end
					if (ctl.vld) begin
						priority if (sts.match) begin
							state_q <= S_IDLE;
						end else if (scan_last) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_FIN: begin
					if (op_q == OP_ACCESS) begin
						state_q <= S_IDLE;
					end else begin
						strobe_q <= 1'b1;
						if (best_zero || round_last) begin
							state_q <= S_IDLE;
						end else begin
							round_q <= round_q + RW'(1);
							iss_q   <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			key_q <= phys[ADDR_W-1:ADDR_W-TAG_W];
		end
		idx_s1 <= iss_q[AW-1:0];
		if (state_q == S_FIN && op_q == OP_REPORT) begin
			found_q <= !best_zero;
			last_q  <= best_zero || round_last;
			count_q <= sts.sel_hits;
			base_q  <= best_zero ? '0 : {sts.sel_tag, (ADDR_W - TAG_W)'(0)};
		end
	end

	assign busy        = state_q != S_IDLE;
	assign strobe      = strobe_q;
	assign bucket_base = base_q;
	assign hit_count   = count_q;
	assign found       = found_q;
	assign last        = last_q;

	`HAB_ASSERT(a_last_frees, (strobe && last) |-> !busy)
	`HAB_ASSERT(a_more_keeps_busy, (strobe && !last) |-> busy)
	`HAB_ASSERT(a_notfound_is_last, (strobe && !found) |-> (last && hit_count == 0))
	`HAB_ASSERT(a_start_takes, (start && !busy) |=> busy)
endmodule

// ===== bench/tb_hot_address_bucket_counter.sv =====
// ----------------------------------------------------------------------------
// tb_hot_address_bucket_counter
// self-checking bench for the hot address bucket counter
// ----------------------------------------------------------------------------
// a queue of requests feeds a clocked driver; each accepted request updates a
// local copy of the bucket table, and reports push the expected ranking.
// a clocked monitor checks every strobed result against the oldest
// expectation. directed requests cover the empty report, address wrap, stale
// tags and a full top-n report; random requests mix a hot bucket pool with
// scattered addresses under several sender idle rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hot_address_bucket_counter;
	import hab_pkg::*;

	localparam int ENTRIES     = DEF_ENTRIES;
	localparam int TOP_N       = DEF_TOP_N;
	localparam int CLK_PERIOD  = 12;
	localparam int STALL_LIMIT = 20 * (ENTRIES + 2);
	localparam int RAND_REQS   = 86;
	localparam int POOL_SIZE   = 16;

	typedef struct {
		logic              op;
		logic [ADDR_W-1:0] offset;
		int unsigned       idle_pct;
		bit                drain;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [HITS_W-1:0] hits;
		logic              found;
		logic              last;
	} rank_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              start         = 1'b0;
	logic              op            = OP_ACCESS;
	logic [ADDR_W-1:0] access_offset = '0;
	logic              busy;
	logic              strobe;
	logic [ADDR_W-1:0] bucket_base;
	logic [HITS_W-1:0] hit_count;
	logic              found;
	logic              last;

	req_t  req_q[$];
	rank_t hot_rank_q[$];

	logic [TAG_W-1:0]  tag_tbl  [ENTRIES];
	logic [HITS_W-1:0] hits_tbl [ENTRIES];

	logic [ADDR_W-1:0] hot_pool [POOL_SIZE];

	int unsigned errors     = 0;
	int unsigned accepted_n = 0;
	int unsigned access_n   = 0;
	int unsigned report_n   = 0;
	int unsigned checked_n  = 0;
	int unsigned total_reqs = 0;
	int unsigned idle_run   = 0;

	hot_address_bucket_counter #(
		.ENTRIES(ENTRIES),
		.TOP_N  (TOP_N)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.access_offset(access_offset),
		.strobe       (strobe),
		.bucket_base  (bucket_base),
		.hit_count    (hit_count),
		.found        (found),
		.last         (last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	// bucket table update for one access
	task automatic tally_access(input logic [ADDR_W-1:0] offset);
		logic [ADDR_W-1:0] phys;
		logic [TAG_W-1:0]  tag;
		logic [HITS_W-1:0] least;
		int                victim;
		phys   = ACCESS_BASE + offset;
		tag    = phys[ADDR_W-1:4];
		victim = 0;
		least  = hits_tbl[0];
		for (int i = 0; i < ENTRIES; i++) begin
			if (tag_tbl[i] == tag) begin
				if (hits_tbl[i] != HITS_MAX)
					hits_tbl[i] = hits_tbl[i] + 1'b1;
				return;
			end
			if (hits_tbl[i] < least) begin
				least  = hits_tbl[i];
				victim = i;
			end
		end
		tag_tbl[victim]  = tag;
		hits_tbl[victim] = 1;
	endtask

	// hottest buckets in order, each cleared once ranked
	task automatic rank_hottest();
		logic [HITS_W-1:0] best;
		int                pick;
		rank_t             res;
		for (int r = 0; r < TOP_N; r++) begin
			best = '0;
			pick = 0;
			for (int i = 0; i < ENTRIES; i++) begin
				if (hits_tbl[i] > best) begin
					best = hits_tbl[i];
					pick = i;
				end
			end
			res.base  = '0;
			res.hits  = '0;
			res.found = 1'b0;
			res.last  = 1'b1;
			if (best == '0) begin
				hot_rank_q.push_back(res);
				return;
			end
			res.base     = {tag_tbl[pick], 4'h0};
			res.hits     = best;
			res.found    = 1'b1;
			res.last     = (r == TOP_N - 1);
			hits_tbl[pick] = '0;
			hot_rank_q.push_back(res);
		end
	endtask

	task automatic queue_req(input logic rop, input logic [ADDR_W-1:0] offset,
			input int unsigned idle_pct, input bit drain);
		req_t r;
		r.op       = rop;
		r.offset   = offset;
		r.idle_pct = idle_pct;
		r.drain    = drain;
		req_q.push_back(r);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin : drive
		req_t cur;
		bit   go;
		if (!arst_n) begin
			start         <= 1'b0;
			op            <= OP_ACCESS;
			access_offset <= '0;
		end else begin
			go = start && !busy;
			if (go) begin
				accepted_n++;
				if (op == OP_REPORT) begin
					report_n++;
					rank_hottest();
				end else begin
					access_n++;
					tally_access(access_offset);
				end
			end
			if (go || !start) begin
				if (req_q.size() != 0 && $urandom_range(99) >= req_q[0].idle_pct &&
						!(req_q[0].drain && hot_rank_q.size() != 0)) begin
					cur = req_q.pop_front();
					start         <= 1'b1;
					op            <= cur.op;
					access_offset <= cur.offset;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		rank_t want;
		if (arst_n && strobe) begin
			if (hot_rank_q.size() == 0) begin
				flag_mismatch("unexpected result, bucket_base", bucket_base, '0);
			end else begin
				want = hot_rank_q.pop_front();
				checked_n++;
				if (bucket_base !== want.base)
					flag_mismatch("bucket_base", bucket_base, want.base);
				if (hit_count !== want.hits)
					flag_mismatch("hit_count", hit_count, want.hits);
				if (found !== want.found)
					flag_mismatch("found", found, want.found);
				if (last !== want.last)
					flag_mismatch("last", last, want.last);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				idle_run = 0;
			else
				idle_run++;
			if (idle_run >= STALL_LIMIT) begin
				$display("[%0t] timeout: no progress for %0d cycles", $realtime, idle_run);
				$display("hot_address_bucket_counter test failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned phase_idle;
		int unsigned pick;
		logic [ADDR_W-1:0] offset;

		for (int i = 0; i < ENTRIES; i++) begin
			tag_tbl[i]  = '0;
			hits_tbl[i] = '0;
		end
		for (int i = 0; i < POOL_SIZE; i++)
			hot_pool[i] = $urandom() & 32'hCFFF_FFF0;

		// directed
		queue_req(OP_REPORT, 32'hDEAD_BEEF, 0, 1'b0);  // empty table
		queue_req(OP_ACCESS, 32'hF000_0000, 0, 1'b0);  // wraps to tag zero
		queue_req(OP_ACCESS, 32'h0000_0000, 0, 1'b0);
		queue_req(OP_ACCESS, 32'h0000_000F, 0, 1'b0);
		queue_req(OP_ACCESS, 32'hFFFF_FFFF, 0, 1'b0);
		queue_req(OP_ACCESS, 32'hCFFF_FFFF, 0, 1'b0);
		queue_req(OP_ACCESS, 32'hAAAA_AAAA, 0, 1'b0);
		queue_req(OP_ACCESS, 32'h5555_5555, 0, 1'b0);
		queue_req(OP_REPORT, 32'hFFFF_FFFF, 0, 1'b0);  // ends early
		for (int j = 1; j <= 11; j++)
			queue_req(OP_ACCESS, 32'h0010_0000 * j + j, 0, 1'b0);
		queue_req(OP_ACCESS, 32'h0030_0007, 0, 1'b0);
		queue_req(OP_ACCESS, 32'h0070_000C, 0, 1'b0);
		queue_req(OP_REPORT, 32'h0000_0000, 0, 1'b0);  // full top-n
		queue_req(OP_REPORT, 32'h1234_5678, 0, 1'b0);
		queue_req(OP_ACCESS, 32'h0030_0000, 0, 1'b1);  // stale tag, counts in place

		// random
		for (int k = 0; k < RAND_REQS; k++) begin
			case ((k * 4) / RAND_REQS)
				1:       phase_idle = 64;
				2:       phase_idle = 35;
				default: phase_idle = 0;
			endcase
			pick = $urandom_range(99);
			if (pick < 9) begin
				queue_req(OP_REPORT, $urandom(), phase_idle, (k % 20) == 0);
			end else begin
				if (pick < 70)
					offset = hot_pool[$urandom_range(POOL_SIZE - 1)] | $urandom_range(15);
				else
					offset = $urandom();
				queue_req(OP_ACCESS, offset, phase_idle, (k % 20) == 0);
			end
		end
		queue_req(OP_REPORT, $urandom(), 0, 1'b1);
		total_reqs = req_q.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (accepted_n != total_reqs || hot_rank_q.size() != 0);
		repeat (ENTRIES + 20) @(posedge clk);

		$display("covered %0d requests: %0d accesses and %0d reports", accepted_n, access_n,
				report_n);
		$display("checked %0d ranked results, %0d mismatches", checked_n, errors);
		if (errors == 0)
			$display("hot_address_bucket_counter test passed");
		else
			$display("hot_address_bucket_counter test failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hab_pkg.sv
rtl/hab_mem.sv
rtl/hab_scan.sv
rtl/hot_address_bucket_counter.sv
bench/tb_hot_address_bucket_counter.sv
